FILE: sv/rsas_pkg.sv
package rsas_pkg;

  localparam int NUM_DIGITS = 8;
  localparam int DIGIT_BITS = 6;
  localparam int RES_DIGITS = NUM_DIGITS + 1;
  localparam int MAG_BITS   = NUM_DIGITS * DIGIT_BITS;
  localparam int RES_BITS   = RES_DIGITS * DIGIT_BITS;
  localparam int LEN_BITS   = 4;
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;

  localparam logic [DIGIT_BITS-1:0] RADIX_RESET = 6'd10;
  localparam logic [DIGIT_BITS-1:0] RADIX_MIN   = 6'd2;
  localparam logic [DIGIT_BITS-1:0] RADIX_MAX   = 6'd36;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_RADIX = 1'b0;

  typedef struct packed {
    logic                operation;
    logic                a_negative;
    logic [MAG_BITS-1:0] a_digits;
    logic                b_negative;
    logic [MAG_BITS-1:0] b_digits;
  } op_t;

  typedef struct packed {
    logic                result_negative;
    logic [RES_BITS-1:0] result_digits;
    logic [LEN_BITS-1:0] result_length;
    logic                invalid;
  } res_t;

  // Word moving down the cell chain. The operand vectors shift right one digit
  // per cell; the three candidate results shift in from the top.
  typedef struct packed {
    logic                valid;
    logic                neg_a;
    logic                neg_b;
    logic [MAG_BITS-1:0] a;
    logic [MAG_BITS-1:0] b;
    logic [MAG_BITS-1:0] sum_d;
    logic [MAG_BITS-1:0] ab_d;
    logic [MAG_BITS-1:0] ba_d;
    logic                carry;
    logic                borrow_ab;
    logic                borrow_ba;
    logic                bad;
  } stage_t;

endpackage

FILE: sv/rsas_cell.sv
module rsas_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [rsas_pkg::DIGIT_BITS-1:0]    radix,
  input  rsas_pkg::stage_t                   prev,
  output rsas_pkg::stage_t                   next
);

  localparam int DB = rsas_pkg::DIGIT_BITS;
  localparam int MB = rsas_pkg::MAG_BITS;

  logic [DB-1:0]  da;
  logic [DB-1:0]  db;
  logic [DB:0]    r_ext;
  logic [DB:0]    sum;
  logic [DB:0]    sub_ab;
  logic [DB:0]    sub_ba;
  logic [DB-1:0]  sum_dig;
  logic [DB-1:0]  ab_dig;
  logic [DB-1:0]  ba_dig;
  logic           carry_o;
  logic           borrow_ab_o;
  logic           borrow_ba_o;
  rsas_pkg::stage_t next_next;

  always_comb begin
    da     = prev.a[DB-1:0];
    db     = prev.b[DB-1:0];
    r_ext  = {1'b0, radix};

    // Ripple step of the sum path.
    sum     = {1'b0, da} + {1'b0, db} + {{DB{1'b0}}, prev.carry};
    carry_o = (sum >= r_ext);
    sum_dig = carry_o ? DB'(sum - r_ext) : sum[DB-1:0];

    // Both differences run side by side; the resolver picks one at the end.
    sub_ab      = {1'b0, db} + {{DB{1'b0}}, prev.borrow_ab};
    borrow_ab_o = ({1'b0, da} < sub_ab);
    ab_dig      = borrow_ab_o ? DB'({1'b0, da} + r_ext - sub_ab) : DB'({1'b0, da} - sub_ab);

    sub_ba      = {1'b0, da} + {{DB{1'b0}}, prev.borrow_ba};
    borrow_ba_o = ({1'b0, db} < sub_ba);
    ba_dig      = borrow_ba_o ? DB'({1'b0, db} + r_ext - sub_ba) : DB'({1'b0, db} - sub_ba);

    next_next           = prev;
    next_next.a         = {{DB{1'b0}}, prev.a[MB-1:DB]};
    next_next.b         = {{DB{1'b0}}, prev.b[MB-1:DB]};
    next_next.sum_d     = {sum_dig, prev.sum_d[MB-1:DB]};
    next_next.ab_d      = {ab_dig, prev.ab_d[MB-1:DB]};
    next_next.ba_d      = {ba_dig, prev.ba_d[MB-1:DB]};
    next_next.carry     = carry_o;
    next_next.borrow_ab = borrow_ab_o;
    next_next.borrow_ba = borrow_ba_o;
    next_next.bad       = prev.bad | ({1'b0, da} >= r_ext) | ({1'b0, db} >= r_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next <= '0;
    end else begin
      next <= next_next;
    end
  end

endmodule

FILE: sv/rsas_resolve.sv
module rsas_resolve (
  input  logic             clk,
  input  logic             rst,
  input  rsas_pkg::stage_t last,
  output logic             done,
  output rsas_pkg::res_t   result
);

  localparam int DB = rsas_pkg::DIGIT_BITS;
  localparam int RB = rsas_pkg::RES_BITS;
  localparam int LB = rsas_pkg::LEN_BITS;

  logic [RB-1:0]  digits;
  logic           neg;
  logic [LB-1:0]  len;
  rsas_pkg::res_t result_next;

  always_comb begin
    if (last.neg_a == last.neg_b) begin
      digits = {{(DB-1){1'b0}}, last.carry, last.sum_d};
      neg    = last.neg_a;
    end else if (!last.borrow_ab) begin
      digits = {{DB{1'b0}}, last.ab_d};
      neg    = last.neg_a;
    end else begin
      digits = {{DB{1'b0}}, last.ba_d};
      neg    = last.neg_b;
    end

    len = '0;
    for (int i = 0; i < rsas_pkg::RES_DIGITS; i++) begin
      if (digits[i*DB +: DB] != '0) begin
        len = LB'(i + 1);
      end
    end

    if (last.bad) begin
      result_next = '0;
      result_next.invalid = 1'b1;
    end else begin
      result_next.result_negative = neg & (len != '0);
      result_next.result_digits   = digits;
      result_next.result_length   = len;
      result_next.invalid         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.valid;
    end
  end

endmodule

FILE: sv/radix_signed_add_sub_core.sv
// Sign-magnitude adder and subtractor over digit vectors in a programmable
// radix from 2 to 36.
//
// The block takes one command word whenever start is high; busy is always low,
// so a new word may follow in every cycle. Each word carries the operation,
// two signs and two magnitudes of eight 6-bit digits. The result word appears
// on result for exactly one cycle, marked by done, after the eight cell
// registers and the resolve register. Throughput is one word per cycle.
//
// The pipeline is the chain of eight digit cells: each cell handles one
// digit position per cycle and hands the ripple carry and both borrows to its
// neighbor, followed by one resolve stage that picks the sum or a difference
// and counts the significant digits.
//
// The receiver cannot stall: results are not held, so it must take done
// whenever it appears. Reset clears the chain's valid bits, so no result comes
// out of a reset, and sets the radix register to ten. The radix is written
// over the APB port at byte address 0, by the user only while the pipeline is
// empty, which the block does not enforce. Values outside 2 to 36 are clamped.
module radix_signed_add_sub_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  rsas_pkg::op_t                       operands,
  output logic                                done,
  output rsas_pkg::res_t                      result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rsas_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [rsas_pkg::DATA_BITS-1:0]      pwdata,
  output logic [rsas_pkg::DATA_BITS-1:0]      prdata,
  output logic                                pready
);

  localparam int DB = rsas_pkg::DIGIT_BITS;
  localparam int N  = rsas_pkg::NUM_DIGITS;

  logic [DB-1:0]     radix;
  logic [DB-1:0]     radix_next;
  logic [DB-1:0]     eff_radix;
  rsas_pkg::stage_t  chain [N+1];

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Configuration register. Only the word address bit selects the register.
  always_comb begin
    radix_next = radix;
    if (psel && penable && pwrite && (paddr[2] == rsas_pkg::REG_RADIX)) begin
      radix_next = pwdata[DB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= rsas_pkg::RADIX_RESET;
    end else begin
      radix <= radix_next;
    end
  end

  always_comb begin
    if (paddr[2] == rsas_pkg::REG_RADIX) begin
      prdata = {{(rsas_pkg::DATA_BITS-DB){1'b0}}, radix};
    end else begin
      prdata = '0;
    end
  end

  // Out-of-range radix values act as the nearest legal base.
  always_comb begin
    if (radix < rsas_pkg::RADIX_MIN) begin
      eff_radix = rsas_pkg::RADIX_MIN;
    end else if (radix > rsas_pkg::RADIX_MAX) begin
      eff_radix = rsas_pkg::RADIX_MAX;
    end else begin
      eff_radix = radix;
    end
  end

  // Head of the chain: subtraction is an add with the second sign flipped.
  always_comb begin
    chain[0]           = '0;
    chain[0].valid     = start;
    chain[0].neg_a     = operands.a_negative;
    chain[0].neg_b     = operands.b_negative ^ operands.operation;
    chain[0].a         = operands.a_digits;
    chain[0].b         = operands.b_digits;
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    rsas_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .radix (eff_radix),
      .prev  (chain[k]),
      .next  (chain[k+1])
    );
  end

  rsas_resolve u_resolve (
    .clk    (clk),
    .rst    (rst),
    .last   (chain[N]),
    .done   (done),
    .result (result)
  );

endmodule

FILE: sim/rsas_check_pkg.sv
`timescale 1ns / 100ps

package rsas_check_pkg;

  import rsas_pkg::*;

  class signed_sum_tracker;

    logic [DIGIT_BITS-1:0] radix_reg;
    res_t                  awaited[$];
    int unsigned           errors;
    int unsigned           checked;
    int unsigned           invalid_seen;
    int unsigned           zero_seen;
    int unsigned           carry_seen;

    function new();
      radix_reg    = RADIX_RESET;
      errors       = 0;
      checked      = 0;
      invalid_seen = 0;
      zero_seen    = 0;
      carry_seen   = 0;
    endfunction

    // The block clamps the programmed base into the legal range.
    function int unsigned digit_base();
      if (radix_reg < RADIX_MIN) return 32'(RADIX_MIN);
      if (radix_reg > RADIX_MAX) return 32'(RADIX_MAX);
      return 32'(radix_reg);
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function res_t predict_result(op_t w);
      int unsigned base;
      int unsigned carry;
      int unsigned borrow;
      int unsigned total;
      int unsigned take;
      int unsigned len;
      int unsigned ad [NUM_DIGITS];
      int unsigned bd [NUM_DIGITS];
      int unsigned major [NUM_DIGITS];
      int unsigned minor [NUM_DIGITS];
      int unsigned rd [RES_DIGITS];
      int          order;
      logic        sign_a;
      logic        sign_b;
      logic        neg;
      logic        bad;
      res_t        r;
      base   = digit_base();
      sign_a = w.a_negative;
      sign_b = w.b_negative ^ w.operation;
      bad    = 1'b0;
      neg    = 1'b0;
      len    = 0;
      r      = '0;
      for (int i = 0; i < RES_DIGITS; i++) rd[i] = 0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        ad[i] = 32'(w.a_digits[i*DIGIT_BITS +: DIGIT_BITS]);
        bd[i] = 32'(w.b_digits[i*DIGIT_BITS +: DIGIT_BITS]);
        if (ad[i] >= base || bd[i] >= base) bad = 1'b1;
      end
      if (bad) begin
        r.invalid = 1'b1;
        return r;
      end
      if (sign_a == sign_b) begin
        carry = 0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
          total = ad[i] + bd[i] + carry;
          carry = (total >= base) ? 1 : 0;
          rd[i] = carry ? total - base : total;
        end
        rd[NUM_DIGITS] = carry;
        neg = sign_a;
      end else begin
        order = 0;
        for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
          if (order == 0) begin
            if (ad[i] > bd[i]) order = 1;
            else if (ad[i] < bd[i]) order = -1;
          end
        end
        if (order < 0) begin
          major = bd;
          minor = ad;
          neg   = sign_b;
        end else begin
          major = ad;
          minor = bd;
          neg   = sign_a;
        end
        borrow = 0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
          take = minor[i] + borrow;
          if (major[i] < take) begin
            rd[i]  = major[i] + base - take;
            borrow = 1;
          end else begin
            rd[i]  = major[i] - take;
            borrow = 0;
          end
        end
      end
      for (int i = 0; i < RES_DIGITS; i++) begin
        if (rd[i] != 0) len = i + 1;
        r.result_digits[i*DIGIT_BITS +: DIGIT_BITS] = DIGIT_BITS'(rd[i]);
      end
      r.result_negative = (len != 0) && neg;
      r.result_length   = LEN_BITS'(len);
      return r;
    endfunction

    function void note_operands(op_t w);
      awaited.push_back(predict_result(w));
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, expected none, got %p", $time, got);
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (want.invalid) invalid_seen++;
      else if (want.result_length == 0) zero_seen++;
      if (want.result_digits[NUM_DIGITS*DIGIT_BITS +: DIGIT_BITS] != 0) carry_seen++;
      compare_field("result_negative", 64'(want.result_negative), 64'(got.result_negative));
      compare_field("result_digits", 64'(want.result_digits), 64'(got.result_digits));
      compare_field("result_length", 64'(want.result_length), 64'(got.result_length));
      compare_field("invalid", 64'(want.invalid), 64'(got.invalid));
    endfunction

  endclass

endpackage

FILE: sim/radix_signed_add_sub_core_test.sv
`timescale 1ns / 100ps

module radix_signed_add_sub_core_test;

  import rsas_pkg::*;
  import rsas_check_pkg::*;

  localparam logic        OP_ADD          = 1'b0;
  localparam logic        OP_SUB          = 1'b1;
  localparam int unsigned RESET_CYCLES    = 7;
  // Pipeline depth from an accepted word to its result.
  localparam int unsigned PIPE_LATENCY    = 9;
  localparam int unsigned WORDS_PER_PHASE = 48;
  // The longest sender gap plus the pipeline depth is far below this limit, so
  // reaching it can only mean a hang.
  localparam int unsigned WATCHDOG_LIMIT  = 1000;

  logic                 clk     = 1'b0;
  logic                 rst     = 1'b1;
  logic                 start   = 1'b0;
  op_t                  operands = '0;
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [ADDR_BITS-1:0] paddr   = '0;
  logic [DATA_BITS-1:0] pwdata  = '0;
  logic                 busy;
  logic                 done;
  res_t                 result;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  signed_sum_tracker    board;
  int unsigned          words_sent = 0;
  int unsigned          quiet      = 0;
  // Radix settings visited after the reset value; the eighth entry is
  // replaced by a random base at run time. The list covers both clamped
  // extremes below and above the legal range as well as the legal ends.
  int unsigned          radix_plan [9] = '{2, 36, 0, 63, 1, 37, 16, 5, 10};

  radix_signed_add_sub_core dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .operands (operands),
    .done     (done),
    .result   (result),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Results cannot be held off, so every done pulse is checked on the edge
  // that ends it.
  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
  end

  // The watchdog restarts on any accepted word, result or register write.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("radix_signed_add_sub_core_test: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Builds a magnitude from a decimal number, for the directed words.
  function automatic logic [MAG_BITS-1:0] decimal_magnitude(longint unsigned v);
    logic [MAG_BITS-1:0] m;
    m = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      m[i*DIGIT_BITS +: DIGIT_BITS] = DIGIT_BITS'(v % 10);
      v = v / 10;
    end
    return m;
  endfunction

  function automatic op_t word_of(logic op, logic an, logic [MAG_BITS-1:0] a,
                                  logic bn, logic [MAG_BITS-1:0] b);
    op_t w;
    w.operation  = op;
    w.a_negative = an;
    w.a_digits   = a;
    w.b_negative = bn;
    w.b_digits   = b;
    return w;
  endfunction

  // A legal magnitude in the given base; one in four gets a random length up to
  // the full width so that the top digits may be zero padding.
  function automatic logic [MAG_BITS-1:0] random_magnitude(int unsigned base);
    logic [MAG_BITS-1:0] m;
    int unsigned         top;
    m   = '0;
    top = ($urandom_range(0, 3) == 0) ? $urandom_range(1, NUM_DIGITS) : NUM_DIGITS;
    for (int i = 0; i < top; i++)
      m[i*DIGIT_BITS +: DIGIT_BITS] = DIGIT_BITS'($urandom_range(0, base - 1));
    return m;
  endfunction

  // Most words are well formed, with biases toward equal and nearly equal
  // magnitudes (zero results and deep compares) and toward all-top digits
  // (a carry rippling into the extra digit). The rest carry an illegal
  // digit or are raw noise.
  function automatic op_t random_word(int unsigned base);
    op_t         w;
    int unsigned pick;
    int unsigned pos;
    w.operation  = 1'($urandom_range(0, 1));
    w.a_negative = 1'($urandom_range(0, 1));
    w.b_negative = 1'($urandom_range(0, 1));
    w.a_digits   = random_magnitude(base);
    w.b_digits   = random_magnitude(base);
    pick = $urandom_range(0, 99);
    pos  = $urandom_range(0, NUM_DIGITS - 1);
    if (pick < 12) begin
      w.b_digits = w.a_digits;
    end else if (pick < 20) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        w.a_digits[i*DIGIT_BITS +: DIGIT_BITS] = DIGIT_BITS'(base - 1);
        w.b_digits[i*DIGIT_BITS +: DIGIT_BITS] = DIGIT_BITS'(base - 1);
      end
    end else if (pick < 28) begin
      w.b_digits = w.a_digits;
      w.b_digits[pos*DIGIT_BITS +: DIGIT_BITS] = DIGIT_BITS'($urandom_range(0, base - 1));
    end else if (pick < 38) begin
      if ($urandom_range(0, 1) == 0)
        w.a_digits[pos*DIGIT_BITS +: DIGIT_BITS] = DIGIT_BITS'($urandom_range(base, 63));
      else
        w.b_digits[pos*DIGIT_BITS +: DIGIT_BITS] = DIGIT_BITS'($urandom_range(base, 63));
    end else if (pick < 42) begin
      w.a_digits = MAG_BITS'({$urandom(), $urandom()});
      w.b_digits = MAG_BITS'({$urandom(), $urandom()});
    end
    return w;
  endfunction

  // Presents one word and holds it until the block takes it. Called right
  // after a rising edge, so start is assigned once in this time step.
  task automatic send_word(op_t w);
    start    <= 1'b1;
    operands <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_operands(w);
    words_sent++;
  endtask

  // Random words in bursts of random length; a steady phase sends back to
  // back with no gaps at all.
  task automatic run_words(int unsigned count, bit steady);
    int unsigned burst;
    burst = $urandom_range(1, 24);
    for (int unsigned k = 0; k < count; k++) begin
      send_word(random_word(board.digit_base()));
      if (!steady && k + 1 < count) begin
        burst--;
        if (burst == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
          burst = $urandom_range(1, 24);
        end
      end
    end
  endtask

  // Stops sending and waits until every expected result word has arrived.
  // Every word yields a result, so the pipeline is empty at that point.
  task automatic drain();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // APB write of the radix register: setup cycle, then access cycle until
  // pready. Upper data bits are random since the register keeps six bits.
  task automatic write_radix(logic [DIGIT_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_RADIX, 2'b00};
    pwdata  <= {26'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.radix_reg = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    op_t opening[$];
    board = new();
    radix_plan[7] = $urandom_range(3, 35);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset radix of ten: zero and negative zero
    // operands, full-width carry into the extra digit, equal magnitudes
    // cancelling to a positive zero, the smaller-minus-larger sign flip,
    // a long borrow ripple, and illegal digits at both ends of the vector.
    opening.push_back(word_of(OP_ADD, 1'b0, decimal_magnitude(0), 1'b0, decimal_magnitude(0)));
    opening.push_back(word_of(OP_ADD, 1'b1, decimal_magnitude(0), 1'b1, decimal_magnitude(0)));
    opening.push_back(word_of(OP_SUB, 1'b0, decimal_magnitude(0), 1'b1, decimal_magnitude(0)));
    opening.push_back(word_of(OP_ADD, 1'b0, decimal_magnitude(99999999),
                              1'b0, decimal_magnitude(99999999)));
    opening.push_back(word_of(OP_ADD, 1'b1, decimal_magnitude(99999999),
                              1'b1, decimal_magnitude(1)));
    opening.push_back(word_of(OP_ADD, 1'b0, decimal_magnitude(99999999),
                              1'b0, decimal_magnitude(1)));
    opening.push_back(word_of(OP_SUB, 1'b0, decimal_magnitude(99999999),
                              1'b0, decimal_magnitude(99999999)));
    opening.push_back(word_of(OP_SUB, 1'b0, decimal_magnitude(1), 1'b0, decimal_magnitude(2)));
    opening.push_back(word_of(OP_SUB, 1'b1, decimal_magnitude(5), 1'b1, decimal_magnitude(3)));
    opening.push_back(word_of(OP_SUB, 1'b0, decimal_magnitude(12345678),
                              1'b0, decimal_magnitude(87654321)));
    opening.push_back(word_of(OP_SUB, 1'b0, decimal_magnitude(10000000),
                              1'b0, decimal_magnitude(1)));
    opening.push_back(word_of(OP_ADD, 1'b0, decimal_magnitude(5), 1'b1, decimal_magnitude(3)));
    opening.push_back(word_of(OP_ADD, 1'b1, decimal_magnitude(5), 1'b0, decimal_magnitude(30)));
    opening.push_back(word_of(OP_SUB, 1'b0, decimal_magnitude(0),
                              1'b0, decimal_magnitude(99999999)));
    opening.push_back(word_of(OP_SUB, 1'b1, decimal_magnitude(99999999),
                              1'b0, decimal_magnitude(99999999)));
    opening.push_back(word_of(OP_ADD, 1'b0, MAG_BITS'(10), 1'b0, decimal_magnitude(7)));
    opening.push_back(word_of(OP_SUB, 1'b0, decimal_magnitude(7),
                              1'b1, {6'd63, {(MAG_BITS-DIGIT_BITS){1'b0}}}));
    opening.push_back(word_of(OP_ADD, 1'b1, '1, 1'b1, '1));
    opening.push_back(word_of(OP_SUB, 1'b0, {NUM_DIGITS{6'b101010}},
                              1'b1, {NUM_DIGITS{6'b010101}}));
    foreach (opening[i]) send_word(opening[i]);
    drain();

    // One phase per radix setting, each with random words; about one phase
    // in four runs with no sender gaps.
    foreach (radix_plan[p]) begin
      write_radix(DIGIT_BITS'(radix_plan[p]));
      run_words(WORDS_PER_PHASE, $urandom_range(0, 3) == 0);
      drain();
    end

    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (board.pending() != 0) begin
      board.errors++;
      $display("%0t: result words missing, expected %0d more, got 0", $time,
               board.pending());
    end

    $display("Sent %0d words over %0d radix settings, checked %0d results.",
             words_sent, $size(radix_plan) + 1, board.checked);
    $display("Results seen: %0d invalid, %0d zero, %0d with a carry digit.",
             board.invalid_seen, board.zero_seen, board.carry_seen);
    if (board.errors == 0) begin
      $display("radix_signed_add_sub_core_test: done, clean");
    end else begin
      $display("radix_signed_add_sub_core_test: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/rsas_pkg.sv
sv/rsas_cell.sv
sv/rsas_resolve.sv
sv/radix_signed_add_sub_core.sv
sim/rsas_check_pkg.sv
sim/radix_signed_add_sub_core_test.sv
